// File: rtl/core/irf_pkg.sv
// Shared types, constants and helper functions of the integer radix formatter.
package irf_pkg;

  // Value and text sizes
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MAX_WIDTH  = 63;
  localparam int unsigned MAX_OUT    = 64;
  localparam int unsigned ND_W       = $clog2(VALUE_BITS + 1);
  localparam int unsigned POS_W      = $clog2(MAX_OUT);
  localparam int unsigned BND_W      = 8;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  // Valid radix range
  localparam logic [5:0] BASE_MIN = 6'd2;
  localparam logic [5:0] BASE_MAX = 6'd36;
  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_HEX = 6'd16;

  // Format flag bit positions
  localparam int unsigned FLAG_ZEROPAD = 0;
  localparam int unsigned FLAG_SIGNED  = 1;
  localparam int unsigned FLAG_PLUS    = 2;
  localparam int unsigned FLAG_SPACE   = 3;
  localparam int unsigned FLAG_LEFT    = 4;
  localparam int unsigned FLAG_ALT     = 5;
  localparam int unsigned FLAG_UPPER   = 6;

  // ASCII codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  // Scaled reciprocal numerator: 2**VALUE_BITS
  localparam logic [VALUE_BITS:0] RECIP_NUM = {1'b1, {VALUE_BITS{1'b0}}};

  // Classified item passed from the front to the back
  typedef struct packed {
    logic                    bad;
    logic [VALUE_BITS-1:0]   mag;
    logic [5:0]              base;
    logic [5:0]              prec;
    logic signed [BND_W-1:0] room;
    logic                    sign_n;
    logic [7:0]              sign_char;
    logic [1:0]              pfx_n;
    logic                    zero_pad;
    logic                    left;
    logic                    upper;
  } irf_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_PAD,
    ST_BOUND,
    ST_EMIT,
    ST_ERR
  } irf_state_e;

  // floor(2**VALUE_BITS / base) for the valid radixes
  function automatic logic [VALUE_BITS-1:0] recip(input logic [5:0] b);
    logic [VALUE_BITS-1:0] r;
    unique case (b)
      6'd2:    r = VALUE_BITS'(RECIP_NUM / 2);
      6'd3:    r = VALUE_BITS'(RECIP_NUM / 3);
      6'd4:    r = VALUE_BITS'(RECIP_NUM / 4);
      6'd5:    r = VALUE_BITS'(RECIP_NUM / 5);
      6'd6:    r = VALUE_BITS'(RECIP_NUM / 6);
      6'd7:    r = VALUE_BITS'(RECIP_NUM / 7);
      6'd8:    r = VALUE_BITS'(RECIP_NUM / 8);
      6'd9:    r = VALUE_BITS'(RECIP_NUM / 9);
      6'd10:   r = VALUE_BITS'(RECIP_NUM / 10);
      6'd11:   r = VALUE_BITS'(RECIP_NUM / 11);
      6'd12:   r = VALUE_BITS'(RECIP_NUM / 12);
      6'd13:   r = VALUE_BITS'(RECIP_NUM / 13);
      6'd14:   r = VALUE_BITS'(RECIP_NUM / 14);
      6'd15:   r = VALUE_BITS'(RECIP_NUM / 15);
      6'd16:   r = VALUE_BITS'(RECIP_NUM / 16);
      6'd17:   r = VALUE_BITS'(RECIP_NUM / 17);
      6'd18:   r = VALUE_BITS'(RECIP_NUM / 18);
      6'd19:   r = VALUE_BITS'(RECIP_NUM / 19);
      6'd20:   r = VALUE_BITS'(RECIP_NUM / 20);
      6'd21:   r = VALUE_BITS'(RECIP_NUM / 21);
      6'd22:   r = VALUE_BITS'(RECIP_NUM / 22);
      6'd23:   r = VALUE_BITS'(RECIP_NUM / 23);
      6'd24:   r = VALUE_BITS'(RECIP_NUM / 24);
      6'd25:   r = VALUE_BITS'(RECIP_NUM / 25);
      6'd26:   r = VALUE_BITS'(RECIP_NUM / 26);
      6'd27:   r = VALUE_BITS'(RECIP_NUM / 27);
      6'd28:   r = VALUE_BITS'(RECIP_NUM / 28);
      6'd29:   r = VALUE_BITS'(RECIP_NUM / 29);
      6'd30:   r = VALUE_BITS'(RECIP_NUM / 30);
      6'd31:   r = VALUE_BITS'(RECIP_NUM / 31);
      6'd32:   r = VALUE_BITS'(RECIP_NUM / 32);
      6'd33:   r = VALUE_BITS'(RECIP_NUM / 33);
      6'd34:   r = VALUE_BITS'(RECIP_NUM / 34);
      6'd35:   r = VALUE_BITS'(RECIP_NUM / 35);
      6'd36:   r = VALUE_BITS'(RECIP_NUM / 36);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Digit value to ASCII, lower or upper case letters
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] alpha;
    logic [7:0] c;
    alpha = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 6'd10) begin
      c = CH_ZERO + {2'b00, d};
    end else begin
      c = alpha + {2'b00, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/irf_front.sv
// Front stage: accepts input items, classifies sign, prefix and field room.
module irf_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [irf_pkg::VALUE_BITS-1:0]   value_i,
  input  logic [5:0]                       base_i,
  input  logic [5:0]                       width_i,
  input  logic [5:0]                       precision_i,
  input  logic [6:0]                       format_flags_i,
  output logic                             item_valid_o,
  input  logic                             item_ready_i,
  output irf_pkg::irf_item_t               item_o
);

  logic               valid_q, valid_d;
  irf_pkg::irf_item_t item_q, item_d;
  logic               accept;
  logic               left, neg;
  logic [5:0]         width_sat;

  // Hold while the queue refuses the registered item
  assign full_o       = valid_q & ~item_ready_i;
  assign accept       = push_i & ~full_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // Classify the incoming item
  always_comb begin
    left      = format_flags_i[irf_pkg::FLAG_LEFT];
    neg       = format_flags_i[irf_pkg::FLAG_SIGNED] & value_i[irf_pkg::VALUE_BITS-1];
    width_sat = (width_i > 6'(irf_pkg::MAX_WIDTH)) ? 6'(irf_pkg::MAX_WIDTH) : width_i;

    item_d.bad      = (base_i < irf_pkg::BASE_MIN) || (base_i > irf_pkg::BASE_MAX);
    item_d.mag      = neg ? (irf_pkg::VALUE_BITS'(0) - value_i) : value_i;
    item_d.base     = base_i;
    item_d.prec     = precision_i;
    item_d.sign_n   = format_flags_i[irf_pkg::FLAG_SIGNED] &
                      (neg | format_flags_i[irf_pkg::FLAG_PLUS] |
                       format_flags_i[irf_pkg::FLAG_SPACE]);
    item_d.zero_pad = format_flags_i[irf_pkg::FLAG_ZEROPAD] & ~left;
    item_d.left     = left;
    item_d.upper    = format_flags_i[irf_pkg::FLAG_UPPER];

    priority if (neg) begin
      item_d.sign_char = irf_pkg::CH_MINUS;
    end else if (format_flags_i[irf_pkg::FLAG_PLUS]) begin
      item_d.sign_char = irf_pkg::CH_PLUS;
    end else begin
      item_d.sign_char = irf_pkg::CH_SPACE;
    end

    priority if (!format_flags_i[irf_pkg::FLAG_ALT]) begin
      item_d.pfx_n = 2'd0;
    end else if (base_i == irf_pkg::BASE_HEX) begin
      item_d.pfx_n = 2'd2;
    end else if (base_i == irf_pkg::BASE_OCT) begin
      item_d.pfx_n = 2'd1;
    end else begin
      item_d.pfx_n = 2'd0;
    end

    item_d.room = irf_pkg::BND_W'(width_sat) - irf_pkg::BND_W'(item_d.sign_n)
                - irf_pkg::BND_W'(item_d.pfx_n);
  end

  // Advance the valid flag
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the classified item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// File: rtl/core/irf_queue.sv
// Short queue of classified items between the front and the back.
module irf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enq_valid_i,
  output logic               enq_ready_o,
  input  irf_pkg::irf_item_t enq_item_i,
  output logic               deq_valid_o,
  input  logic               deq_ready_i,
  output irf_pkg::irf_item_t deq_item_o
);

  irf_pkg::irf_item_t                slot_q [irf_pkg::QDEPTH];
  logic [irf_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [irf_pkg::QCNT_W-1:0]        count_q;
  logic                              enq, deq;

  assign enq_ready_o = (count_q != irf_pkg::QCNT_W'(irf_pkg::QDEPTH));
  assign deq_valid_o = (count_q != '0);
  assign enq         = enq_valid_i & enq_ready_o;
  assign deq         = deq_valid_o & deq_ready_i;
  assign deq_item_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_q <= (wr_ptr_q == irf_pkg::QPTR_W'(irf_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (deq) begin
        rd_ptr_q <= (rd_ptr_q == irf_pkg::QPTR_W'(irf_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (enq && !deq) begin
        count_q <= count_q + 1'b1;
      end else if (deq && !enq) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Write the entering item
  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_ptr_q] <= enq_item_i;
    end
  end

endmodule

// File: rtl/core/irf_back.sv
// Back stage: digit conversion by reciprocal multiply, layout and character output.
module irf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  input  irf_pkg::irf_item_t item_i,
  output logic               out_empty_o,
  input  logic               out_pop_i,
  output logic [7:0]         char_code_o,
  output logic               last_o,
  output logic               bad_base_o
);

  localparam int unsigned VB = irf_pkg::VALUE_BITS;
  localparam int unsigned BW = irf_pkg::BND_W;

  irf_pkg::irf_state_e         state_q, state_d;
  irf_pkg::irf_item_t          item_q;
  logic [VB-1:0]               mag_q, recip_q, qest_q;
  logic [irf_pkg::ND_W-1:0]    nd_q;
  logic [5:0]                  stack_q [VB];
  logic [BW-1:0]               precp_q, pad_q;
  logic [BW-1:0]               b1_q, b2_q, b3_q, b5_q, b6_q;
  logic [irf_pkg::POS_W-1:0]   pos_q, last_pos_q;
  logic                        out_valid_q;
  logic [7:0]                  char_q;
  logic                        last_q, bad_q;

  logic                        out_free;
  logic                        do_load, do_mul, do_fix, do_pad, do_bound, do_emit, do_err;

  // Digit step datapath
  logic [2*VB-1:0]             prod;
  logic [6:0]                  qb7, r7;
  logic                        fix_up;
  logic [5:0]                  dig;
  logic [VB-1:0]               q_next;

  // Layout datapath
  logic [BW-1:0]               nd_x, prec_x, precp;
  logic signed [BW:0]          pad_s;
  logic [BW-1:0]               pad;
  logic [BW-1:0]               lead_n, zpad_n, trail_n;
  logic [BW-1:0]               b1, b2, b3, b5, b6, total;
  logic [irf_pkg::POS_W-1:0]   last_pos;

  // Character select
  logic [BW-1:0]               pos_x;
  logic [7:0]                  emit_char;
  logic                        pop_dig;
  logic                        emit_last;

  assign out_free    = ~out_valid_q | out_pop_i;
  assign out_empty_o = ~out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign bad_base_o  = bad_q;

  // One quotient estimate per digit, then a single correction step
  always_comb begin
    prod   = (2*VB)'(mag_q) * (2*VB)'(recip_q);
    qb7    = qest_q[6:0] * 7'(item_q.base);
    r7     = mag_q[6:0] - qb7;
    fix_up = (r7 >= 7'(item_q.base));
    dig    = fix_up ? 6'(r7 - 7'(item_q.base)) : 6'(r7);
    q_next = qest_q + VB'(fix_up);
  end

  // Pad length from the digit count
  always_comb begin
    nd_x   = BW'(nd_q);
    prec_x = BW'(item_q.prec);
    precp  = (nd_x > prec_x) ? nd_x : prec_x;
    pad_s  = {item_q.room[BW-1], item_q.room} - $signed({1'b0, precp});
    pad    = pad_s[BW] ? '0 : pad_s[BW-1:0];
  end

  // Region boundaries of the text
  always_comb begin
    lead_n  = (!item_q.zero_pad && !item_q.left) ? pad_q : '0;
    zpad_n  = item_q.zero_pad ? pad_q : '0;
    trail_n = item_q.left ? pad_q : '0;
    b1      = lead_n;
    b2      = b1 + BW'(item_q.sign_n);
    b3      = b2 + BW'(item_q.pfx_n);
    b6      = b3 + zpad_n + precp_q;
    b5      = b6 - BW'(nd_q);
    total   = b6 + trail_n;
    last_pos = (total > BW'(irf_pkg::MAX_OUT)) ? irf_pkg::POS_W'(irf_pkg::MAX_OUT - 1)
                                               : irf_pkg::POS_W'(total - 1'b1);
  end

  // Pick the character at the current position
  always_comb begin
    pos_x     = BW'(pos_q);
    pop_dig   = 1'b0;
    emit_last = (pos_q == last_pos_q);
    priority if (pos_x < b1_q) begin
      emit_char = irf_pkg::CH_SPACE;
    end else if (pos_x < b2_q) begin
      emit_char = item_q.sign_char;
    end else if (pos_x < b3_q) begin
      emit_char = (pos_x == b2_q) ? irf_pkg::CH_ZERO
                : (item_q.upper ? irf_pkg::CH_UPPER_X : irf_pkg::CH_LOWER_X);
    end else if (pos_x < b5_q) begin
      emit_char = irf_pkg::CH_ZERO;
    end else if (pos_x < b6_q) begin
      emit_char = irf_pkg::digit_char(stack_q[0], item_q.upper);
      pop_dig   = 1'b1;
    end else begin
      emit_char = irf_pkg::CH_SPACE;
    end
  end

  // Sequence one item at a time
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    do_load    = 1'b0;
    do_mul     = 1'b0;
    do_fix     = 1'b0;
    do_pad     = 1'b0;
    do_bound   = 1'b0;
    do_emit    = 1'b0;
    do_err     = 1'b0;
    unique case (state_q)
      irf_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          do_load    = 1'b1;
          state_d    = item_i.bad ? irf_pkg::ST_ERR : irf_pkg::ST_MUL;
        end
      end
      irf_pkg::ST_MUL: begin
        do_mul  = 1'b1;
        state_d = irf_pkg::ST_FIX;
      end
      irf_pkg::ST_FIX: begin
        do_fix  = 1'b1;
        state_d = (q_next == '0) ? irf_pkg::ST_PAD : irf_pkg::ST_MUL;
      end
      irf_pkg::ST_PAD: begin
        do_pad  = 1'b1;
        state_d = irf_pkg::ST_BOUND;
      end
      irf_pkg::ST_BOUND: begin
        do_bound = 1'b1;
        state_d  = irf_pkg::ST_EMIT;
      end
      irf_pkg::ST_EMIT: begin
        if (out_free) begin
          do_emit = 1'b1;
          if (emit_last) begin
            state_d = irf_pkg::ST_IDLE;
          end
        end
      end
      irf_pkg::ST_ERR: begin
        if (out_free) begin
          do_err  = 1'b1;
          state_d = irf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = irf_pkg::ST_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_emit || do_err) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the conversion and layout
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      item_q  <= item_i;
      mag_q   <= item_i.mag;
      recip_q <= irf_pkg::recip(item_i.base);
      nd_q    <= '0;
      pos_q   <= '0;
    end
    if (do_mul) begin
      qest_q <= prod[2*VB-1:VB];
    end
    if (do_fix) begin
      mag_q <= q_next;
      nd_q  <= nd_q + 1'b1;
    end
    if (do_pad) begin
      precp_q <= precp;
      pad_q   <= pad;
    end
    if (do_bound) begin
      b1_q       <= b1;
      b2_q       <= b2;
      b3_q       <= b3;
      b5_q       <= b5;
      b6_q       <= b6;
      last_pos_q <= last_pos;
    end
    if (do_emit) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  // Push digits least significant first, pop most significant first
  always_ff @(posedge clk_i) begin
    if (do_fix) begin
      stack_q[0] <= dig;
      for (int i = 1; i < VB; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (do_emit && pop_dig) begin
      for (int i = 0; i < VB - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
      bad_q  <= 1'b0;
    end else if (do_err) begin
      char_q <= irf_pkg::CH_NUL;
      last_q <= 1'b1;
      bad_q  <= 1'b1;
    end
  end

  a_err_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_q |-> last_q)
    else $error("error result without last");

  a_digit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == irf_pkg::ST_FIX |-> nd_q < irf_pkg::ND_W'(VB))
    else $error("digit stack overflow");

  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == irf_pkg::ST_EMIT |-> pos_q <= last_pos_q)
    else $error("character position past end of text");

endmodule

// File: rtl/core/integer_radix_formatter.sv
// Top level of the integer radix formatter: front, item queue and back.
//
//   channel  | handshake    | payload
//   ---------+--------------+------------------------------------------------------
//   input    | push / full  | value_i, base_i, width_i, precision_i, format_flags_i
//   result   | empty / pop  | char_code_o, last_o, bad_base_o
//
// After its transfer an item is registered in the front and then enters the queue.
// The back loads it, runs a reciprocal multiply and a correction step per digit,
// works out the pad and the region boundaries, and emits the characters in order.
// A bad radix skips the conversion and yields a single error character. Reset is
// asynchronous, control state only, no clearing pass. full rises when front register
// and two-entry queue are occupied; an unpopped character in the output register
// stalls the back.
module integer_radix_formatter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [irf_pkg::VALUE_BITS-1:0] value_i,
  input  logic [5:0]                     base_i,
  input  logic [5:0]                     width_i,
  input  logic [5:0]                     precision_i,
  input  logic [6:0]                     format_flags_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     char_code_o,
  output logic                           last_o,
  output logic                           bad_base_o
);

  irf_pkg::irf_item_t front_item, queue_item;
  logic               front_valid, queue_ready;
  logic               queue_valid, back_pop;

  // Accept and classify
  irf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .value_i        (value_i),
    .base_i         (base_i),
    .width_i        (width_i),
    .precision_i    (precision_i),
    .format_flags_i (format_flags_i),
    .item_valid_o   (front_valid),
    .item_ready_i   (queue_ready),
    .item_o         (front_item)
  );

  // Decouple the two sides
  irf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (front_valid),
    .enq_ready_o (queue_ready),
    .enq_item_i  (front_item),
    .deq_valid_o (queue_valid),
    .deq_ready_i (back_pop),
    .deq_item_o  (queue_item)
  );

  // Convert and emit characters
  irf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_pop_o   (back_pop),
    .item_i       (queue_item),
    .out_empty_o  (empty),
    .out_pop_i    (pop),
    .char_code_o  (char_code_o),
    .last_o       (last_o),
    .bad_base_o   (bad_base_o)
  );

endmodule

// File: sim/integer_radix_formatter_test.sv
// Self-checking testbench for the integer radix formatter: directed table, then random items.
`timescale 1ns / 100ps

module integer_radix_formatter_test;

  import irf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned RANDOM_ITEMS = 400;

  // Format flag masks
  localparam logic [6:0] FMT_ZERO   = 7'(1 << FLAG_ZEROPAD);
  localparam logic [6:0] FMT_SIGNED = 7'(1 << FLAG_SIGNED);
  localparam logic [6:0] FMT_PLUS   = 7'(1 << FLAG_PLUS);
  localparam logic [6:0] FMT_SPACE  = 7'(1 << FLAG_SPACE);
  localparam logic [6:0] FMT_LEFT   = 7'(1 << FLAG_LEFT);
  localparam logic [6:0] FMT_ALT    = 7'(1 << FLAG_ALT);
  localparam logic [6:0] FMT_UPPER  = 7'(1 << FLAG_UPPER);

  localparam string LOWER_DIGITS = "0123456789abcdefghijklmnopqrstuvwxyz";
  localparam string UPPER_DIGITS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam int    X_INDEX      = 33;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            base;
    logic [5:0]            width;
    logic [5:0]            prec;
    logic [6:0]            flags;
  } fmt_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       bad;
  } char_rec_t;

  // How a directed row gets its expected text
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_TEXT,
    CHK_BAD_BASE
  } row_check_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [VALUE_BITS-1:0] value_i;
  logic [5:0]            base_i;
  logic [5:0]            width_i;
  logic [5:0]            precision_i;
  logic [6:0]            format_flags_i;
  logic                  empty;
  logic                  pop;
  logic [7:0]            char_code_o;
  logic                  last_o;
  logic                  bad_base_o;

  char_rec_t  char_expect_q[$];
  char_rec_t  want;
  fmt_item_t  row_item_q[$];
  row_check_e row_check_q[$];
  string      row_text_q[$];
  int         mismatch_count;
  int         cycle_count;
  logic       calm;

  integer_radix_formatter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .value_i        (value_i),
    .base_i         (base_i),
    .width_i        (width_i),
    .precision_i    (precision_i),
    .format_flags_i (format_flags_i),
    .empty          (empty),
    .pop            (pop),
    .char_code_o    (char_code_o),
    .last_o         (last_o),
    .bad_base_o     (bad_base_o)
  );

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Work out the characters one item produces and queue them
  function automatic void predict_text(input fmt_item_t it);
    byte unsigned digits[$];
    byte unsigned line[$];
    string        charset;
    logic [VALUE_BITS-1:0] mag;
    int unsigned  radix;
    int           room;
    int           prec;
    int           pad;
    int           n;
    logic         zero_fill;
    logic         left;
    logic         has_sign;
    byte unsigned sign_ch;
    charset   = it.flags[FLAG_UPPER] ? UPPER_DIGITS : LOWER_DIGITS;
    radix     = it.base;
    mag       = it.value;
    room      = (it.width > MAX_WIDTH) ? MAX_WIDTH : int'(it.width);
    prec      = it.prec;
    left      = it.flags[FLAG_LEFT];
    zero_fill = it.flags[FLAG_ZEROPAD] && !left;
    has_sign  = 1'b0;
    sign_ch   = CH_SPACE;

    // Bad radix: one error character and nothing else
    if (radix < BASE_MIN || radix > BASE_MAX) begin
      char_expect_q.push_back('{code: CH_NUL, last: 1'b1, bad: 1'b1});
      return;
    end

    // Sign takes one place of the field
    if (it.flags[FLAG_SIGNED]) begin
      if (mag[VALUE_BITS-1]) begin
        has_sign = 1'b1;
        sign_ch  = CH_MINUS;
        mag      = -mag;
      end else if (it.flags[FLAG_PLUS]) begin
        has_sign = 1'b1;
        sign_ch  = CH_PLUS;
      end else if (it.flags[FLAG_SPACE]) begin
        has_sign = 1'b1;
        sign_ch  = CH_SPACE;
      end
    end
    if (has_sign) room--;
    if (it.flags[FLAG_ALT]) begin
      if (radix == BASE_HEX) room -= 2;
      else if (radix == BASE_OCT) room--;
    end

    // Digits, least significant first
    if (mag == '0) begin
      digits.push_back(CH_ZERO);
    end else begin
      while (mag != '0) begin
        digits.push_back(charset[int'(mag % radix)]);
        mag = mag / radix;
      end
    end
    if (digits.size() > prec) prec = digits.size();
    room -= prec;
    pad = (room > 0) ? room : 0;

    // Assemble the field
    if (!zero_fill && !left) repeat (pad) line.push_back(CH_SPACE);
    if (has_sign) line.push_back(sign_ch);
    if (it.flags[FLAG_ALT] && radix == BASE_OCT) line.push_back(CH_ZERO);
    if (it.flags[FLAG_ALT] && radix == BASE_HEX) begin
      line.push_back(CH_ZERO);
      line.push_back(charset[X_INDEX]);
    end
    if (zero_fill) repeat (pad) line.push_back(CH_ZERO);
    repeat (prec - digits.size()) line.push_back(CH_ZERO);
    for (int k = digits.size() - 1; k >= 0; k--) line.push_back(digits[k]);
    if (left) repeat (pad) line.push_back(CH_SPACE);

    // Only the first MAX_OUT characters leave the block
    n = (line.size() > MAX_OUT) ? MAX_OUT : line.size();
    for (int k = 0; k < n; k++) begin
      char_expect_q.push_back('{code: line[k], last: (k == n - 1), bad: 1'b0});
    end
  endfunction

  function automatic void add_row(input logic [VALUE_BITS-1:0] value, input logic [5:0] base,
                                  input logic [5:0] width, input logic [5:0] prec,
                                  input logic [6:0] flags, input row_check_e check,
                                  input string text);
    row_item_q.push_back('{value: value, base: base, width: width, prec: prec, flags: flags});
    row_check_q.push_back(check);
    row_text_q.push_back(text);
  endfunction

  // Random item, weighted toward common radixes and short fields
  function automatic fmt_item_t random_item();
    fmt_item_t it;
    int unsigned pick;
    case ($urandom_range(7))
      0:       it.value = $urandom_range(40);
      1:       it.value = 32'hFFFF_FFFF - $urandom_range(40);
      2:       it.value = 32'h8000_0000 + $urandom_range(40);
      3:       it.value = 32'd1 << $urandom_range(31);
      default: it.value = $urandom;
    endcase
    pick = $urandom_range(99);
    if (pick < 6) begin
      it.base = $urandom_range(1) ? 6'($urandom_range(1)) : 6'($urandom_range(63, 37));
    end else if (pick < 30) begin
      it.base = 6'd10;
    end else if (pick < 45) begin
      it.base = BASE_HEX;
    end else if (pick < 55) begin
      it.base = BASE_OCT;
    end else if (pick < 60) begin
      it.base = BASE_MIN;
    end else begin
      it.base = 6'($urandom_range(BASE_MAX, BASE_MIN));
    end
    it.width = ($urandom_range(99) < 15) ? 6'($urandom_range(63)) : 6'($urandom_range(16));
    pick = $urandom_range(99);
    if (pick < 10) it.prec = 6'($urandom_range(63));
    else if (pick < 40) it.prec = 6'($urandom_range(12, 1));
    else it.prec = '0;
    it.flags = 7'($urandom_range(127));
    return it;
  endfunction

  // Drive one item and hold it until the transfer
  task automatic send_item(input fmt_item_t it);
    if (!calm && $urandom_range(99) < 12) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 12);
    end
    push           <= 1'b1;
    value_i        <= it.value;
    base_i         <= it.base;
    width_i        <= it.width;
    precision_i    <= it.prec;
    format_flags_i <= it.flags;
    do @(posedge clk_i); while (full);
  endtask

  // Hold off the sender until every expected character is out
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (char_expect_q.size() != 0);
  endtask

  // Stimulus
  initial begin
    fmt_item_t it;
    string     text;
    push           <= 1'b0;
    value_i        <= '0;
    base_i         <= '0;
    width_i        <= '0;
    precision_i    <= '0;
    format_flags_i <= '0;
    mismatch_count = 0;
    calm           = 1'b0;

    add_row(32'd0,         6'd10, 6'd0,  6'd0,  7'd0,       CHK_TEXT, "0");
    add_row(32'hFFFF_FFFF, 6'd10, 6'd0,  6'd0,  FMT_SIGNED, CHK_TEXT, "-1");
    add_row(32'h8000_0000, 6'd10, 6'd0,  6'd0,  FMT_SIGNED, CHK_TEXT, "-2147483648");
    add_row(32'h7FFF_FFFF, 6'd10, 6'd0,  6'd0,  FMT_SIGNED, CHK_TEXT, "2147483647");
    add_row(32'hFFFF_FFFF, 6'd10, 6'd0,  6'd0,  7'd0,       CHK_TEXT, "4294967295");
    add_row(32'hFFFF_FFFF, 6'd16, 6'd0,  6'd0,  7'd0,       CHK_TEXT, "ffffffff");
    add_row(32'hFFFF_FFFF, 6'd16, 6'd0,  6'd0,  FMT_UPPER,  CHK_TEXT, "FFFFFFFF");
    add_row(32'hFFFF_FFFF, 6'd2,  6'd0,  6'd0,  7'd0,       CHK_TEXT,
            "11111111111111111111111111111111");
    add_row(32'd0,         6'd16, 6'd0,  6'd0,  FMT_ALT,    CHK_TEXT, "0x0");
    add_row(32'd255,       6'd16, 6'd0,  6'd0,  FMT_ALT | FMT_UPPER, CHK_TEXT, "0XFF");
    add_row(32'd8,         6'd8,  6'd0,  6'd0,  FMT_ALT,    CHK_TEXT, "010");
    add_row(32'd42,        6'd10, 6'd6,  6'd0,  FMT_ZERO | FMT_SIGNED | FMT_PLUS,
            CHK_TEXT, "+00042");
    add_row(32'd42,        6'd10, 6'd4,  6'd0,  7'd0,       CHK_TEXT, "  42");
    add_row(32'd42,        6'd10, 6'd6,  6'd0,  FMT_LEFT,   CHK_TEXT, "42    ");
    add_row(32'd42,        6'd10, 6'd5,  6'd0,  FMT_LEFT | FMT_ZERO, CHK_TEXT, "42   ");
    add_row(32'd42,        6'd10, 6'd0,  6'd5,  7'd0,       CHK_TEXT, "00042");
    add_row(32'd42,        6'd10, 6'd0,  6'd0,  FMT_SIGNED | FMT_SPACE, CHK_TEXT, " 42");
    add_row(32'd35,        6'd36, 6'd0,  6'd0,  FMT_UPPER,  CHK_TEXT, "Z");
    add_row(32'd7,         6'd0,  6'd0,  6'd0,  7'd0,       CHK_BAD_BASE, "");
    add_row(32'd7,         6'd1,  6'd9,  6'd3,  FMT_SIGNED, CHK_BAD_BASE, "");
    add_row(32'hFFFF_FFFF, 6'd37, 6'd0,  6'd0,  7'd0,       CHK_BAD_BASE, "");
    add_row(32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, 7'h7F,      CHK_BAD_BASE, "");
    add_row(32'd0,         6'd10, 6'd63, 6'd0,  FMT_ZERO,   CHK_PREDICT, "");
    add_row(32'h8000_0000, 6'd16, 6'd63, 6'd63, FMT_SIGNED | FMT_ALT | FMT_ZERO,
            CHK_PREDICT, "");
    add_row(32'd12345,     6'd7,  6'd20, 6'd8,  7'h7F,      CHK_PREDICT, "");

    while (rst_ni !== 1'b1) @(posedge clk_i);
    @(posedge clk_i);

    // Directed table
    foreach (row_item_q[r]) begin
      send_item(row_item_q[r]);
      text = row_text_q[r];
      case (row_check_q[r])
        CHK_TEXT: begin
          for (int k = 0; k < text.len(); k++) begin
            char_expect_q.push_back('{code: text[k], last: (k == text.len() - 1),
                                      bad: 1'b0});
          end
        end
        CHK_BAD_BASE: char_expect_q.push_back('{code: CH_NUL, last: 1'b1, bad: 1'b1});
        default: predict_text(row_item_q[r]);
      endcase
    end
    drain_results();

    // Random items, with one stretch of steady flow on both sides
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 150 && i < 230);
      it = random_item();
      send_item(it);
      predict_text(it);
      if (i == 300) drain_results();
    end
    calm = 1'b0;
    push <= 1'b0;

    // Wait out the remaining characters, then a quiet tail
    while (char_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && char_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: check each transfer, then pick the next pop
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (char_expect_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected character %h last %b bad_base %b", $time,
                   char_code_o, last_o, bad_base_o);
        end else begin
          want = char_expect_q.pop_front();
          if (char_code_o !== want.code) begin
            mismatch_count++;
            $display("%0t: char_code expected %h, got %h", $time, want.code, char_code_o);
          end
          if (last_o !== want.last) begin
            mismatch_count++;
            $display("%0t: last expected %b, got %b", $time, want.last, last_o);
          end
          if (bad_base_o !== want.bad) begin
            mismatch_count++;
            $display("%0t: bad_base expected %b, got %b", $time, want.bad, bad_base_o);
          end
        end
      end
      pop <= calm || ($urandom_range(99) >= 12);
    end
  end

  // Bound the run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
